### hw/rtl/rice_pkg.sv
// ----------------------------------------------------------------------------
// rice_pkg
// Shared types and instruction codes of the integer execute core.
// ----------------------------------------------------------------------------
`default_nettype none

package rice_pkg;

  localparam int unsigned DATA_WORDS_DEF = 1024;
  localparam logic [31:0] START_ADDRESS_RST = 32'h0000_0000;

  // configuration register index (byte address / 4)
  localparam logic REG_START_ADDRESS = 1'b0;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_BREAK   = 6'h0d;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  // REGIMM rt codes
  localparam logic [4:0] RI_BLTZ    = 5'h00;
  localparam logic [4:0] RI_BGEZ    = 5'h01;
  localparam logic [4:0] RI_BLTZAL  = 5'h10;
  localparam logic [4:0] RI_BGEZAL  = 5'h11;

  // COP0 rs codes
  localparam logic [4:0] CP_MF      = 5'h00;
  localparam logic [4:0] CP_MT      = 5'h04;
  localparam logic [4:0] CP_CO      = 5'h10;

  localparam logic [4:0] LINK_REG   = 5'd31;

  typedef enum logic [1:0] {
    MD_MULT,
    MD_MULTU,
    MD_DIV,
    MD_DIVU
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

endpackage

`default_nettype wire

### hw/rtl/rice_if.sv
// ----------------------------------------------------------------------------
// rice_in_if / rice_out_if
// Valid/ready channels for instruction words and execution results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rice_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface rice_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_address;
  logic        halted;
  logic        write_valid;
  logic [4:0]  write_index;
  logic [31:0] write_value;

  modport source (output valid, output fetch_address, output halted,
                  output write_valid, output write_index, output write_value,
                  input ready);
  modport sink   (input valid, input fetch_address, input halted,
                  input write_valid, input write_index, input write_value,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/rice_ram.sv
// ----------------------------------------------------------------------------
// rice_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rice_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rice_muldiv.sv
// ----------------------------------------------------------------------------
// rice_muldiv
// Multi-cycle multiply and radix-2 restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module rice_muldiv (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rice_pkg::md_req_t req,
  input  wire logic [31:0]      a,
  input  wire logic [31:0]      b,
  output logic                  done,
  output logic [31:0]           hi,
  output logic [31:0]           lo
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIX} mstate_t;

  mstate_t     state_r;
  logic [31:0] ma_r, mb_r;
  logic [31:0] rem_r, quo_r;
  logic [63:0] prod_r;
  logic        neg_q_r, neg_r_r, is_div_r;
  logic [4:0]  cnt_r;

  logic        sgn;
  logic [32:0] rem_s, diff;
  logic        ge;
  logic [31:0] rem_n, quo_n;
  logic [63:0] prod_neg;

  assign sgn = (req.op == rice_pkg::MD_MULT) || (req.op == rice_pkg::MD_DIV);

  always_comb begin
    rem_s = {rem_r, quo_r[31]};
    diff  = rem_s - {1'b0, mb_r};
    ge    = !diff[32];
    rem_n = ge ? diff[31:0] : rem_s[31:0];
    quo_n = {quo_r[30:0], ge};
    prod_neg = 64'd0 - prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (req.start) begin
            ma_r     <= (sgn && a[31]) ? 32'd0 - a : a;
            mb_r     <= (sgn && b[31]) ? 32'd0 - b : b;
            neg_q_r  <= sgn && (a[31] ^ b[31]);
            neg_r_r  <= sgn && a[31];
            is_div_r <= (req.op == rice_pkg::MD_DIV) || (req.op == rice_pkg::MD_DIVU);
            rem_r    <= 32'd0;
            quo_r    <= (sgn && a[31]) ? 32'd0 - a : a;
            cnt_r    <= 5'd0;
            state_r  <= ((req.op == rice_pkg::MD_DIV) || (req.op == rice_pkg::MD_DIVU))
                        ? M_DIV : M_MUL;
          end
        end
        M_MUL: begin
          prod_r  <= 64'(ma_r) * 64'(mb_r);
          state_r <= M_FIX;
        end
        M_DIV: begin
          rem_r <= rem_n;
          quo_r <= quo_n;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            state_r <= M_FIX;
          end
        end
        M_FIX: begin
          if (is_div_r) begin
            lo <= neg_q_r ? 32'd0 - quo_r : quo_r;
            hi <= neg_r_r ? 32'd0 - rem_r : rem_r;
          end else begin
            lo <= neg_q_r ? prod_neg[31:0]  : prod_r[31:0];
            hi <= neg_q_r ? prod_neg[63:32] : prod_r[63:32];
          end
          done    <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/risc_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// risc_instruction_execute_core
// MIPS-I integer subset: executes one instruction word per input word and
// returns the next fetch address and any register write-back.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake            | Word
//  --------+-----+----------------------+-------------------------------------
//  in_if   | in  | valid/ready          | instruction
//  out_if  | out | valid/ready          | fetch_address, halted, write_*
//  APB     | in  | psel/penable/pready  | start_address at byte address 0
//
//  An instruction passes from acceptance to a result through read registers,
//  form memory index, execute and finish; the register and data RAMs have
//  registered reads. MULT/MULTU and DIV/DIVU with a non-zero divisor also
//  wait for the multi-cycle unit. When DATA_WORDS is not a power of two
//  the memory index is reduced by a reciprocal multiply, a multiply-subtract
//  and one compare and subtract, as further steps of forming the index.
//  The next word is accepted as soon as the previous result sits in the
//  output register, so a stalled sink costs at most one extra word in flight.
//  Reset is synchronous; the register files need no clearing pass as every
//  entry carries a valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module risc_instruction_execute_core #(
  parameter int unsigned DATA_WORDS = rice_pkg::DATA_WORDS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rice_in_if.sink     in_if,
  rice_out_if.source  out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned AW    = $clog2(DATA_WORDS);
  localparam bit          POW2  = (DATA_WORDS & (DATA_WORDS - 1)) == 0;
  localparam logic [31:0] DW_C  = 32'(DATA_WORDS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DATA_WORDS);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_ADR, S_EX, S_MD, S_FIN} state_t;

  state_t      state_r;
  logic [31:0] start_r, pc_r, bt_r, hi_r, lo_r;
  logic        bp_r;
  logic [31:0] ins_r, a_r, b_r, cp_r, addr_r;
  logic [31:0] gpr_vld_r, cp_vld_r;
  logic [AW-1:0] widx_r;
  logic [63:0] mprod_r;
  logic [31:0] red_r;
  logic [1:0]  cnt_r;

  // pending result and output register
  logic [31:0] res_pc_r, res_wd_r;
  logic        res_halt_r, res_wv_r;
  logic [4:0]  res_wi_r;
  logic        out_valid_r;

  // instruction fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, zimm;
  assign op   = ins_r[31:26];
  assign rs   = ins_r[25:21];
  assign rt   = ins_r[20:16];
  assign rd   = ins_r[15:11];
  assign sh   = ins_r[10:6];
  assign fn   = ins_r[5:0];
  assign imm  = ins_r[15:0];
  assign simm = {{16{imm[15]}}, imm};
  assign zimm = {16'd0, imm};

  logic accept, cfg_wr;
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign pready = 1'b1;
  assign prdata = start_r;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rice_pkg::REG_START_ADDRESS);

  // --------------------------------------------------------------------------
  // Register files: two copies of the general registers (rs and rt ports)
  // --------------------------------------------------------------------------
  logic        gpr_we;
  logic [4:0]  gpr_wa;
  logic [31:0] gpr_wd, gpr_a_q, gpr_b_q, cp_q;
  logic        cp_we;

  rice_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_a (
    .clk, .we(gpr_we), .waddr(gpr_wa), .wdata(gpr_wd),
    .re(accept), .raddr(in_if.instruction[25:21]), .rdata(gpr_a_q)
  );
  rice_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_b (
    .clk, .we(gpr_we), .waddr(gpr_wa), .wdata(gpr_wd),
    .re(accept), .raddr(in_if.instruction[20:16]), .rdata(gpr_b_q)
  );
  rice_ram #(.WIDTH(32), .DEPTH(32)) u_cp0 (
    .clk, .we(cp_we), .waddr(rd), .wdata(b_r),
    .re(accept), .raddr(in_if.instruction[15:11]), .rdata(cp_q)
  );

  // --------------------------------------------------------------------------
  // Data memory index: byte address / 4, wrapped to DATA_WORDS
  // --------------------------------------------------------------------------
  logic [29:0]   word;
  logic [31:0]   red_n;
  logic [AW-1:0] dm_ra;
  logic          dm_re, dm_we;
  logic [31:0]   dm_q, dm_wd;

  // the reciprocal estimate of the quotient is low by at most one, so the
  // remainder left after the multiply-subtract needs one compare and subtract
  assign word  = addr_r[31:2];
  always_comb begin
    red_n = {2'b00, word} - mprod_r[63:32] * DW_C;
    dm_ra = POW2 ? word[AW-1:0]
                 : ((red_r >= DW_C) ? AW'(red_r - DW_C) : red_r[AW-1:0]);
    dm_re = (state_r == S_ADR) && (POW2 || (cnt_r == 2'd0));
  end

  rice_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk, .we(dm_we), .waddr(widx_r), .wdata(dm_wd),
    .re(dm_re), .raddr(dm_ra), .rdata(dm_q)
  );

  // --------------------------------------------------------------------------
  // Multiply / divide unit
  // --------------------------------------------------------------------------
  rice_pkg::md_req_t md_req;
  logic        md_done;
  logic [31:0] md_hi, md_lo;

  rice_muldiv u_md (
    .clk, .rst_n, .req(md_req), .a(a_r), .b(b_r),
    .done(md_done), .hi(md_hi), .lo(md_lo)
  );

  // --------------------------------------------------------------------------
  // Execute decode
  // --------------------------------------------------------------------------
  logic [31:0] npc, link, btgt, jtgt, tgt, wval, hi_nxt, lo_nxt;
  logic        ok, put, take, hi_we, lo_we;
  logic [4:0]  pidx;
  logic [4:0]  bsh;
  logic [7:0]  byte_v;
  logic [15:0] half_v;
  logic [31:0] bmask, hmask;

  always_comb begin
    npc    = bp_r ? bt_r : pc_r + 32'd4;
    link   = npc + 32'd4;
    btgt   = npc + {simm[29:0], 2'b00};
    jtgt   = {npc[31:28], ins_r[25:0], 2'b00};
    bsh    = {addr_r[1:0], 3'b000};
    byte_v = 8'(dm_q >> bsh);
    half_v = addr_r[1] ? dm_q[31:16] : dm_q[15:0];
    bmask  = 32'hff << bsh;
    hmask  = addr_r[1] ? 32'hffff_0000 : 32'h0000_ffff;
    ok = 1'b1; put = 1'b0; pidx = rt; wval = 32'd0;
    take = 1'b0; tgt = btgt;
    hi_we = 1'b0; lo_we = 1'b0; hi_nxt = a_r; lo_nxt = a_r;
    cp_we = 1'b0; dm_we = 1'b0; dm_wd = b_r;
    md_req.start = 1'b0; md_req.op = rice_pkg::MD_MULT;
    if (state_r == S_EX) begin
      unique case (op)
        rice_pkg::OP_SPECIAL: begin
          pidx = rd;
          case (fn)
            rice_pkg::FN_ADD, rice_pkg::FN_ADDU: begin put = 1'b1; wval = a_r + b_r; end
            rice_pkg::FN_SUB, rice_pkg::FN_SUBU: begin put = 1'b1; wval = a_r - b_r; end
            rice_pkg::FN_SLT:  begin put = 1'b1; wval = {31'd0, $signed(a_r) < $signed(b_r)}; end
            rice_pkg::FN_SLTU: begin put = 1'b1; wval = {31'd0, a_r < b_r}; end
            rice_pkg::FN_AND:  begin put = 1'b1; wval = a_r & b_r; end
            rice_pkg::FN_OR:   begin put = 1'b1; wval = a_r | b_r; end
            rice_pkg::FN_XOR:  begin put = 1'b1; wval = a_r ^ b_r; end
            rice_pkg::FN_NOR:  begin put = 1'b1; wval = ~(a_r | b_r); end
            rice_pkg::FN_SLL:  begin put = 1'b1; wval = b_r << sh; end
            rice_pkg::FN_SRL:  begin put = 1'b1; wval = b_r >> sh; end
            rice_pkg::FN_SRA:  begin put = 1'b1; wval = 32'($signed(b_r) >>> sh); end
            rice_pkg::FN_SLLV: begin put = 1'b1; wval = b_r << a_r[4:0]; end
            rice_pkg::FN_SRLV: begin put = 1'b1; wval = b_r >> a_r[4:0]; end
            rice_pkg::FN_SRAV: begin put = 1'b1; wval = 32'($signed(b_r) >>> a_r[4:0]); end
            rice_pkg::FN_JR:   begin take = 1'b1; tgt = a_r; end
            rice_pkg::FN_JALR: begin put = 1'b1; wval = link; take = 1'b1; tgt = a_r; end
            rice_pkg::FN_MFHI: begin put = 1'b1; wval = hi_r; end
            rice_pkg::FN_MFLO: begin put = 1'b1; wval = lo_r; end
            rice_pkg::FN_MTHI: hi_we = 1'b1;
            rice_pkg::FN_MTLO: lo_we = 1'b1;
            rice_pkg::FN_SYSCALL, rice_pkg::FN_BREAK: ;
            rice_pkg::FN_MULT:  begin md_req.start = 1'b1; md_req.op = rice_pkg::MD_MULT; end
            rice_pkg::FN_MULTU: begin md_req.start = 1'b1; md_req.op = rice_pkg::MD_MULTU; end
            rice_pkg::FN_DIV:   begin md_req.start = (b_r != 32'd0); md_req.op = rice_pkg::MD_DIV; end
            rice_pkg::FN_DIVU:  begin md_req.start = (b_r != 32'd0); md_req.op = rice_pkg::MD_DIVU; end
            default: ok = 1'b0;
          endcase
        end
        rice_pkg::OP_REGIMM: begin
          pidx = rice_pkg::LINK_REG;
          wval = link;
          unique case (rt)
            rice_pkg::RI_BLTZ:   take = a_r[31];
            rice_pkg::RI_BGEZ:   take = !a_r[31];
            rice_pkg::RI_BLTZAL: begin take = a_r[31];  put = 1'b1; end
            rice_pkg::RI_BGEZAL: begin take = !a_r[31]; put = 1'b1; end
            default: ok = 1'b0;
          endcase
        end
        rice_pkg::OP_COP0: begin
          unique case (rs)
            rice_pkg::CP_CO: ;
            rice_pkg::CP_MF: begin put = 1'b1; wval = cp_r; end
            rice_pkg::CP_MT: cp_we = 1'b1;
            default: ok = 1'b0;
          endcase
        end
        rice_pkg::OP_J:    begin take = 1'b1; tgt = jtgt; end
        rice_pkg::OP_JAL:  begin
          take = 1'b1; tgt = jtgt; put = 1'b1; pidx = rice_pkg::LINK_REG; wval = link;
        end
        rice_pkg::OP_BEQ:  take = (a_r == b_r);
        rice_pkg::OP_BNE:  take = (a_r != b_r);
        rice_pkg::OP_BGTZ: take = !a_r[31] && (a_r != 32'd0);
        rice_pkg::OP_BLEZ: take = a_r[31] || (a_r == 32'd0);
        rice_pkg::OP_ADDI, rice_pkg::OP_ADDIU: begin put = 1'b1; wval = a_r + simm; end
        rice_pkg::OP_SLTI:  begin put = 1'b1; wval = {31'd0, $signed(a_r) < $signed(simm)}; end
        rice_pkg::OP_SLTIU: begin put = 1'b1; wval = {31'd0, a_r < simm}; end
        rice_pkg::OP_ANDI:  begin put = 1'b1; wval = a_r & zimm; end
        rice_pkg::OP_ORI:   begin put = 1'b1; wval = a_r | zimm; end
        rice_pkg::OP_XORI:  begin put = 1'b1; wval = a_r ^ zimm; end
        rice_pkg::OP_LUI:   begin put = 1'b1; wval = {imm, 16'd0}; end
        rice_pkg::OP_LB:    begin put = 1'b1; wval = {{24{byte_v[7]}}, byte_v}; end
        rice_pkg::OP_LBU:   begin put = 1'b1; wval = {24'd0, byte_v}; end
        rice_pkg::OP_LH:    begin put = 1'b1; wval = {{16{half_v[15]}}, half_v}; end
        rice_pkg::OP_LHU:   begin put = 1'b1; wval = {16'd0, half_v}; end
        rice_pkg::OP_LW:    begin put = 1'b1; wval = dm_q; end
        rice_pkg::OP_SB: begin
          dm_we = 1'b1; dm_wd = (dm_q & ~bmask) | ((b_r & 32'hff) << bsh);
        end
        rice_pkg::OP_SH: begin
          dm_we = 1'b1;
          dm_wd = (dm_q & ~hmask) | (addr_r[1] ? {b_r[15:0], 16'd0} : {16'd0, b_r[15:0]});
        end
        rice_pkg::OP_SW:    dm_we = 1'b1;
        default: ok = 1'b0;
      endcase
    end
    if (md_done) begin
      hi_we = 1'b1; lo_we = 1'b1; hi_nxt = md_hi; lo_nxt = md_lo;
    end
    gpr_we = put && (pidx != 5'd0);
    gpr_wa = pidx;
    gpr_wd = wval;
  end

  // --------------------------------------------------------------------------
  // Sequencer, architectural state and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= rice_pkg::START_ADDRESS_RST;
      pc_r        <= rice_pkg::START_ADDRESS_RST;
      bp_r        <= 1'b0;
      bt_r        <= 32'd0;
      hi_r        <= 32'd0;
      lo_r        <= 32'd0;
      gpr_vld_r   <= 32'd0;
      cp_vld_r    <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output word once taken, unless the finish step refills it
      if (out_if.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        start_r <= pwdata;
        pc_r    <= pwdata;
        bp_r    <= 1'b0;
      end
      if (hi_we) hi_r <= hi_nxt;
      if (lo_we) lo_r <= lo_nxt;
      if (gpr_we) gpr_vld_r[gpr_wa] <= 1'b1;
      if (cp_we)  cp_vld_r[rd] <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            ins_r   <= in_if.instruction;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          // capture operands; invalid entries read as zero
          a_r     <= gpr_vld_r[rs] ? gpr_a_q : 32'd0;
          b_r     <= gpr_vld_r[rt] ? gpr_b_q : 32'd0;
          cp_r    <= cp_vld_r[rd]  ? cp_q    : 32'd0;
          addr_r  <= (gpr_vld_r[rs] ? gpr_a_q : 32'd0) + simm;
          cnt_r   <= 2'd2;
          state_r <= S_ADR;
        end
        S_ADR: begin
          cnt_r <= cnt_r - 2'd1;
          if (cnt_r == 2'd2) mprod_r <= 64'(word) * 64'(RECIP);
          if (cnt_r == 2'd1) red_r <= red_n;
          if (dm_re) begin
            widx_r  <= dm_ra;
            state_r <= S_EX;
          end
        end
        S_EX: begin
          pc_r       <= npc;
          bp_r       <= take;
          if (take) bt_r <= tgt;
          res_pc_r   <= npc;
          res_halt_r <= !ok;
          res_wv_r   <= gpr_we;
          res_wi_r   <= gpr_we ? gpr_wa : 5'd0;
          res_wd_r   <= gpr_we ? gpr_wd : 32'd0;
          state_r    <= md_req.start ? S_MD : S_FIN;
        end
        S_MD: begin
          if (md_done) state_r <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_if.ready) begin
            out_valid_r          <= 1'b1;
            out_if.fetch_address <= res_pc_r;
            out_if.halted        <= res_halt_r;
            out_if.write_valid   <= res_wv_r;
            out_if.write_index   <= res_wi_r;
            out_if.write_value   <= res_wd_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid = out_valid_r;

endmodule

`default_nettype wire

### hw/rtl/rice_checker.sv
// ----------------------------------------------------------------------------
// rice_checker
// Port-level checks of the execute core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rice_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] fetch_address,
  input wire logic        halted,
  input wire logic        write_valid,
  input wire logic [4:0]  write_index,
  input wire logic [31:0] write_value
);

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("word presented straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(fetch_address) && $stable(write_value))
    else $error("stalled result word changed");

  a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && halted |-> !write_valid) else $error("halted word with write-back");

  a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (write_valid ? (write_index != 5'd0)
                               : (write_index == 5'd0 && write_value == 32'd0)))
    else $error("write-back fields inconsistent");

endmodule

bind risc_instruction_execute_core rice_checker u_rice_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .fetch_address (out_if.fetch_address),
  .halted        (out_if.halted),
  .write_valid   (out_if.write_valid),
  .write_index   (out_if.write_index),
  .write_value   (out_if.write_value)
);

`default_nettype wire

### bench/tb_risc_instruction_execute_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_risc_instruction_execute_core
// Self-checking bench for the integer execute core. A scoreboard class keeps
// its own copy of the register files, hi/lo, delay-slot branch state and
// data memory. It predicts every result word from the accepted instruction
// words and checks the result channel in order. The stimulus is a directed
// opening, then random instruction words over several start addresses, with
// bursty input traffic and a stalling result sink.
// ----------------------------------------------------------------------------

typedef struct {
  logic [31:0] fetch_address;
  logic        halted;
  logic        write_valid;
  logic [4:0]  write_index;
  logic [31:0] write_value;
} exec_result_t;

class exec_scoreboard;
  logic [31:0]  gpr [32];
  logic [31:0]  cp0 [32];
  logic [31:0]  dmem [1024];
  bit           dmem_written [1024];
  logic [31:0]  pc, hi, lo, target;
  bit           pending_branch;
  exec_result_t res;
  exec_result_t expected_q [$];
  int unsigned  errors;

  function new();
    for (int i = 0; i < 32; i++) begin
      gpr[i] = '0;
      cp0[i] = '0;
    end
    for (int i = 0; i < 1024; i++) dmem_written[i] = 0;
    pc = rice_pkg::START_ADDRESS_RST;
    hi = '0;
    lo = '0;
    target = '0;
    pending_branch = 0;
    errors = 0;
  endfunction

  function void load_start(logic [31:0] v);
    pc = v;
    pending_branch = 0;
  endfunction

  // Word index of a load/store; the memory size is a power of two.
  function logic [9:0] word_index(logic [31:0] ins);
    logic [31:0] addr;
    addr = gpr[ins[25:21]] + {{16{ins[15]}}, ins[15:0]};
    return addr[11:2];
  endfunction

  function void put(logic [4:0] idx, logic [31:0] v);
    if (idx == 5'd0) return;
    gpr[idx] = v;
    res.write_valid = 1'b1;
    res.write_index = idx;
    res.write_value = v;
  endfunction

  function void branch(bit cond, logic [31:0] simm, bit link);
    if (link) put(rice_pkg::LINK_REG, pc + 32'd4);
    if (cond) begin
      target = pc + (simm << 2);
      pending_branch = 1;
    end
  endfunction

  function void jump(logic [31:0] t);
    target = t;
    pending_branch = 1;
  endfunction

  function logic [31:0] mag(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Execute one instruction word and queue the result it must produce.
  function void note(logic [31:0] ins);
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, simm, a, b, addr, w, q, r, ma, mb;
    logic [9:0]  wi;
    logic [63:0] p;
    int          bl, hl;
    bit          ok;
    op = ins[31:26];
    rs = ins[25:21];
    rt = ins[20:16];
    rd = ins[15:11];
    sh = ins[10:6];
    fn = ins[5:0];
    imm = {16'd0, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    a = gpr[rs];
    b = gpr[rt];
    addr = a + simm;
    wi = addr[11:2];
    w = dmem[wi];
    bl = addr[1:0] * 8;
    hl = addr[1] * 16;
    ok = 1;
    res = '{default: '0};

    if (pending_branch) begin
      pc = target;
      pending_branch = 0;
    end else begin
      pc = pc + 32'd4;
    end

    case (op)
      rice_pkg::OP_SPECIAL: begin
        case (fn)
          rice_pkg::FN_ADD, rice_pkg::FN_ADDU: put(rd, a + b);
          rice_pkg::FN_SUB, rice_pkg::FN_SUBU: put(rd, a - b);
          rice_pkg::FN_SLT:  put(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
          rice_pkg::FN_SLTU: put(rd, (a < b) ? 32'd1 : 32'd0);
          rice_pkg::FN_AND:  put(rd, a & b);
          rice_pkg::FN_OR:   put(rd, a | b);
          rice_pkg::FN_XOR:  put(rd, a ^ b);
          rice_pkg::FN_NOR:  put(rd, ~(a | b));
          rice_pkg::FN_SLL:  put(rd, b << sh);
          rice_pkg::FN_SRL:  put(rd, b >> sh);
          rice_pkg::FN_SRA:  put(rd, $signed(b) >>> sh);
          rice_pkg::FN_SLLV: put(rd, b << a[4:0]);
          rice_pkg::FN_SRLV: put(rd, b >> a[4:0]);
          rice_pkg::FN_SRAV: put(rd, $signed(b) >>> a[4:0]);
          rice_pkg::FN_JR:   jump(a);
          rice_pkg::FN_JALR: begin
            put(rd, pc + 32'd4);
            jump(a);
          end
          rice_pkg::FN_MFHI: put(rd, hi);
          rice_pkg::FN_MFLO: put(rd, lo);
          rice_pkg::FN_MTHI: hi = a;
          rice_pkg::FN_MTLO: lo = a;
          rice_pkg::FN_SYSCALL, rice_pkg::FN_BREAK: ;
          rice_pkg::FN_MULT, rice_pkg::FN_MULTU: begin
            if (fn == rice_pkg::FN_MULTU) begin
              p = {32'd0, a} * {32'd0, b};
            end else begin
              p = {32'd0, mag(a)} * {32'd0, mag(b)};
              if (a[31] ^ b[31]) p = 64'd0 - p;
            end
            lo = p[31:0];
            hi = p[63:32];
          end
          rice_pkg::FN_DIV, rice_pkg::FN_DIVU: begin
            // divide by zero leaves hi/lo alone
            if (b != 32'd0) begin
              if (fn == rice_pkg::FN_DIVU) begin
                lo = a / b;
                hi = a % b;
              end else begin
                ma = mag(a);
                mb = mag(b);
                q = ma / mb;
                r = ma % mb;
                if (a[31] ^ b[31]) q = 32'd0 - q;
                if (a[31]) r = 32'd0 - r;
                lo = q;
                hi = r;
              end
            end
          end
          default: ok = 0;
        endcase
      end
      rice_pkg::OP_REGIMM: begin
        case (rt)
          rice_pkg::RI_BLTZ:   branch(a[31], simm, 0);
          rice_pkg::RI_BGEZ:   branch(!a[31], simm, 0);
          rice_pkg::RI_BLTZAL: branch(a[31], simm, 1);
          rice_pkg::RI_BGEZAL: branch(!a[31], simm, 1);
          default:   ok = 0;
        endcase
      end
      rice_pkg::OP_COP0: begin
        case (rs)
          rice_pkg::CP_CO: ;
          rice_pkg::CP_MF: put(rt, cp0[rd]);
          rice_pkg::CP_MT: cp0[rd] = b;
          default: ok = 0;
        endcase
      end
      rice_pkg::OP_J:   jump({pc[31:28], ins[25:0], 2'b00});
      rice_pkg::OP_JAL: begin
        put(rice_pkg::LINK_REG, pc + 32'd4);
        jump({pc[31:28], ins[25:0], 2'b00});
      end
      rice_pkg::OP_BEQ:  branch(a == b, simm, 0);
      rice_pkg::OP_BNE:  branch(a != b, simm, 0);
      rice_pkg::OP_BGTZ: branch(!a[31] && a != 32'd0, simm, 0);
      rice_pkg::OP_BLEZ: branch(a[31] || a == 32'd0, simm, 0);
      rice_pkg::OP_ADDI, rice_pkg::OP_ADDIU: put(rt, a + simm);
      rice_pkg::OP_SLTI:  put(rt, ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0);
      rice_pkg::OP_SLTIU: put(rt, (a < simm) ? 32'd1 : 32'd0);
      rice_pkg::OP_ANDI:  put(rt, a & imm);
      rice_pkg::OP_ORI:   put(rt, a | imm);
      rice_pkg::OP_XORI:  put(rt, a ^ imm);
      rice_pkg::OP_LUI:   put(rt, imm << 16);
      rice_pkg::OP_LB:    put(rt, {{24{w[bl+7]}}, w[bl +: 8]});
      rice_pkg::OP_LBU:   put(rt, {24'd0, w[bl +: 8]});
      rice_pkg::OP_LH:    put(rt, {{16{w[hl+15]}}, w[hl +: 16]});
      rice_pkg::OP_LHU:   put(rt, {16'd0, w[hl +: 16]});
      rice_pkg::OP_LW:    put(rt, w);
      rice_pkg::OP_SB: begin
        w[bl +: 8] = b[7:0];
        dmem[wi] = w;
      end
      rice_pkg::OP_SH: begin
        w[hl +: 16] = b[15:0];
        dmem[wi] = w;
      end
      rice_pkg::OP_SW: begin
        dmem[wi] = b;
        dmem_written[wi] = 1;
      end
      default: ok = 0;
    endcase
    gpr[0] = '0;
    res.fetch_address = pc;
    res.halted = !ok;
    expected_q.push_back(res);
  endfunction

  function void check(exec_result_t got);
    exec_result_t e;
    if (expected_q.size() == 0) begin
      $error("result word with nothing expected: fetch_address %h", got.fetch_address);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (got.fetch_address !== e.fetch_address) begin
      $error("fetch_address: expected %h, actual %h", e.fetch_address, got.fetch_address);
      errors++;
    end
    if (got.halted !== e.halted) begin
      $error("halted: expected %b, actual %b", e.halted, got.halted);
      errors++;
    end
    if (got.write_valid !== e.write_valid) begin
      $error("write_valid: expected %b, actual %b", e.write_valid, got.write_valid);
      errors++;
    end
    if (got.write_index !== e.write_index) begin
      $error("write_index: expected %0d, actual %0d", e.write_index, got.write_index);
      errors++;
    end
    if (got.write_value !== e.write_value) begin
      $error("write_value: expected %h, actual %h", e.write_value, got.write_value);
      errors++;
    end
  endfunction
endclass

module tb_risc_instruction_execute_core;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rice_in_if  in_bus ();
  rice_out_if out_bus ();

  exec_scoreboard scoreboard = new();
  bit             stim_done = 0;

  risc_instruction_execute_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit: far beyond a run of nothing but divides behind a stalled sink.
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Instruction encoders
  // ---------------------------------------------------------------------
  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {rice_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_cop0(logic [4:0] code, logic [4:0] rt,
                                           logic [4:0] rd, logic [5:0] fn);
    return {rice_pkg::OP_COP0, code, rt, rd, 5'd0, fn};
  endfunction

  function automatic bit is_load(logic [5:0] op);
    return op == rice_pkg::OP_LB || op == rice_pkg::OP_LBU || op == rice_pkg::OP_LH ||
           op == rice_pkg::OP_LHU || op == rice_pkg::OP_LW;
  endfunction

  // Turn a load from a never-written word into a word store to that address,
  // so no load returns memory that holds no defined value.
  function automatic logic [31:0] guard_load(logic [31:0] ins);
    if (is_load(ins[31:26]) && !scoreboard.dmem_written[scoreboard.word_index(ins)])
      ins[31:26] = rice_pkg::OP_SW;
    return ins;
  endfunction

  // Random instruction word: mostly well-formed, with register seeding,
  // memory traffic and some raw noise.
  function automatic logic [31:0] random_word();
    logic [5:0] ops [25] = '{
      rice_pkg::OP_SPECIAL, rice_pkg::OP_REGIMM, rice_pkg::OP_J, rice_pkg::OP_JAL,
      rice_pkg::OP_BEQ, rice_pkg::OP_BNE, rice_pkg::OP_BLEZ, rice_pkg::OP_BGTZ,
      rice_pkg::OP_ADDI, rice_pkg::OP_ADDIU, rice_pkg::OP_SLTI, rice_pkg::OP_SLTIU,
      rice_pkg::OP_ANDI, rice_pkg::OP_ORI, rice_pkg::OP_XORI, rice_pkg::OP_LUI,
      rice_pkg::OP_COP0, rice_pkg::OP_LB, rice_pkg::OP_LH, rice_pkg::OP_LW,
      rice_pkg::OP_LBU, rice_pkg::OP_LHU, rice_pkg::OP_SB, rice_pkg::OP_SH,
      rice_pkg::OP_SW};
    logic [5:0] fns [28] = '{
      rice_pkg::FN_SLL, rice_pkg::FN_SRL, rice_pkg::FN_SRA, rice_pkg::FN_SLLV,
      rice_pkg::FN_SRLV, rice_pkg::FN_SRAV, rice_pkg::FN_JR, rice_pkg::FN_JALR,
      rice_pkg::FN_SYSCALL, rice_pkg::FN_BREAK, rice_pkg::FN_MFHI, rice_pkg::FN_MTHI,
      rice_pkg::FN_MFLO, rice_pkg::FN_MTLO, rice_pkg::FN_MULT, rice_pkg::FN_MULTU,
      rice_pkg::FN_DIV, rice_pkg::FN_DIVU, rice_pkg::FN_ADD, rice_pkg::FN_ADDU,
      rice_pkg::FN_SUB, rice_pkg::FN_SUBU, rice_pkg::FN_AND, rice_pkg::FN_OR,
      rice_pkg::FN_XOR, rice_pkg::FN_NOR, rice_pkg::FN_SLT, rice_pkg::FN_SLTU};
    logic [4:0] rimm [4] = '{rice_pkg::RI_BLTZ, rice_pkg::RI_BGEZ, rice_pkg::RI_BLTZAL,
                             rice_pkg::RI_BGEZAL};
    logic [4:0] cops [3] = '{rice_pkg::CP_MF, rice_pkg::CP_MT, rice_pkg::CP_CO};
    logic [31:0] w;
    int unsigned pick;
    w = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // raw noise, unknown codes included
    end else if (pick < 24) begin
      case ($urandom_range(0, 7))
        0: w[31:26] = rice_pkg::OP_SB;
        1: w[31:26] = rice_pkg::OP_SH;
        2, 3: w[31:26] = rice_pkg::OP_SW;
        4: w[31:26] = rice_pkg::OP_LB;
        5: w[31:26] = rice_pkg::OP_LBU;
        6: w[31:26] = rice_pkg::OP_LHU;
        default: w[31:26] = ($urandom_range(0, 1) != 0) ? rice_pkg::OP_LW : rice_pkg::OP_LH;
      endcase
      if ($urandom_range(0, 2) != 0) w[25:21] = 5'd0;
    end else if (pick < 34) begin
      w[31:26] = ($urandom_range(0, 1) != 0) ? rice_pkg::OP_LUI : rice_pkg::OP_ORI;
    end else begin
      w[31:26] = ops[$urandom_range(0, 24)];
      if (w[31:26] == rice_pkg::OP_SPECIAL) w[5:0] = fns[$urandom_range(0, 27)];
      if (w[31:26] == rice_pkg::OP_REGIMM) w[20:16] = rimm[$urandom_range(0, 3)];
      if (w[31:26] == rice_pkg::OP_COP0) w[25:21] = cops[$urandom_range(0, 2)];
      if (w[31:26] == rice_pkg::OP_COP0 && w[25:21] == rice_pkg::CP_CO) w[5:0] = 6'h18;
    end
    return guard_load(w);
  endfunction

  // ---------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------

  // Offer one word and hold it until the core takes it.
  task automatic send_word(logic [31:0] word);
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.instruction <= word;
    forever begin
      @(posedge clk);
      if (in_bus.ready) break;
    end
    scoreboard.note(word);
  endtask

  task automatic idle_input(int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk);
    in_bus.valid <= 1'b0;
    in_bus.instruction <= $urandom;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Wait until every expected word is back, then let any tail drain.
  task automatic drain();
    idle_input(1);
    while (scoreboard.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_start_address(logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {rice_pkg::REG_START_ADDRESS, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    scoreboard.load_start(v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_burst_traffic(int unsigned items);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < items; i++) begin
        send_word(random_word());
        sent++;
      end
      // gaps of zero keep some stretches back to back
      idle_input(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9));
    end
  endtask

  // ---------------------------------------------------------------------
  // Result sink: stalls in segments of its own, with one long hold-off
  // ---------------------------------------------------------------------
  initial begin
    int unsigned segment;
    int unsigned mode;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    segment = 0;
    forever begin
      if (segment == 6) begin
        // hold off long enough for the core to back up into its input
        for (int c = 0; c < 400; c++) begin
          @(negedge clk);
          out_bus.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      for (int c = 0; c < 60; c++) begin
        @(negedge clk);
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 1) != 0);
          2: out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= ((c % 7) < 5);
        endcase
      end
      segment++;
    end
  end

  // Check every result word taken at a rising edge.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      scoreboard.check('{fetch_address: out_bus.fetch_address, halted: out_bus.halted,
                         write_valid: out_bus.write_valid, write_index: out_bus.write_index,
                         write_value: out_bus.write_value});
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [31:0] directed [$];
    logic [31:0] starts [4];
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.instruction = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening from the reset start address.
    directed = '{
      enc_i(rice_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000),     // r1 = most negative
      enc_i(rice_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hffff),   // r2 = -1
      enc_i(rice_pkg::OP_ORI, 5'd0, 5'd3, 16'hffff),
      enc_i(rice_pkg::OP_LUI, 5'd0, 5'd4, 16'h89ab),
      enc_i(rice_pkg::OP_ORI, 5'd4, 5'd4, 16'hcdef),
      enc_i(rice_pkg::OP_SW, 5'd0, 5'd4, 16'h0000),
      enc_i(rice_pkg::OP_SB, 5'd0, 5'd3, 16'h0001),
      enc_i(rice_pkg::OP_SH, 5'd0, 5'd1, 16'h0003),      // odd halfword address
      enc_i(rice_pkg::OP_LB, 5'd0, 5'd5, 16'h0001),
      enc_i(rice_pkg::OP_LBU, 5'd0, 5'd6, 16'h0003),
      enc_i(rice_pkg::OP_LH, 5'd0, 5'd7, 16'h0002),
      enc_i(rice_pkg::OP_LHU, 5'd0, 5'd8, 16'h0000),
      enc_i(rice_pkg::OP_LW, 5'd0, 5'd9, 16'h1003),      // misaligned and wrapped
      enc_r(rice_pkg::FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0),   // most negative by -1
      enc_r(rice_pkg::FN_MFLO, 5'd0, 5'd0, 5'd10, 5'd0),
      enc_r(rice_pkg::FN_MFHI, 5'd0, 5'd0, 5'd11, 5'd0),
      enc_r(rice_pkg::FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0),
      enc_r(rice_pkg::FN_DIV, 5'd4, 5'd0, 5'd0, 5'd0),   // divide by zero
      enc_r(rice_pkg::FN_MFHI, 5'd0, 5'd0, 5'd12, 5'd0),
      enc_r(rice_pkg::FN_ADD, 5'd1, 5'd2, 5'd0, 5'd0),   // write to r0 dropped
      enc_r(rice_pkg::FN_SRAV, 5'd3, 5'd1, 5'd13, 5'd0),
      enc_cop0(rice_pkg::CP_MT, 5'd4, 5'd12, 6'd0),
      enc_cop0(rice_pkg::CP_MF, 5'd14, 5'd12, 6'd0),
      enc_i(rice_pkg::OP_BEQ, 5'd0, 5'd0, 16'hffff),
      enc_r(rice_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0), // delay slot
      {rice_pkg::OP_JAL, 26'h3ffffff},
      enc_r(rice_pkg::FN_JALR, 5'd4, 5'd0, 5'd15, 5'd0), // jump in a delay slot
      enc_cop0(rice_pkg::CP_CO, 5'd0, 5'd0, 6'h18),
      {6'h3f, 26'h155aaaa},                              // unknown opcode halts
      enc_i(rice_pkg::OP_REGIMM, 5'd1, rice_pkg::RI_BLTZAL, 16'h8000),
      enc_i(rice_pkg::OP_BGTZ, 5'd1, 5'd0, 16'h0010)
    };
    foreach (directed[i]) send_word(directed[i]);
    drain();

    // Random phases across start addresses, extremes first.
    starts = '{32'h0000_0000, 32'hffff_fffc, 32'hffff_ffff, $urandom};
    foreach (starts[i]) begin
      write_start_address(starts[i]);
      random_burst_traffic(380);
      drain();
    end

    if (scoreboard.expected_q.size() != 0) begin
      $error("%0d result words never arrived", scoreboard.expected_q.size());
      scoreboard.errors++;
    end
    if (scoreboard.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### risc_instruction_execute_core.f
hw/rtl/rice_pkg.sv
hw/rtl/rice_if.sv
hw/rtl/rice_ram.sv
hw/rtl/rice_muldiv.sv
hw/rtl/risc_instruction_execute_core.sv
hw/rtl/rice_checker.sv
bench/tb_risc_instruction_execute_core.sv
